[design/gdfs_pkg.sv]
// Shared types and constants for the depth-first search block.
package gdfs_pkg;

    // Fixed field widths
    localparam int VTX_W = 5;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;
    localparam int CNT_W = 6;

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 3'd0,
        ST_VISIT = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_NONE  = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD_WR,
        S_POP,
        S_VISIT,
        S_HEAD,
        S_EDGE,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    head_rd_from;
        logic    head_rd_cur;
        logic    add_commit;
        logic    clear_all;
        logic    push_start;
        logic    pop;
        logic    visit;
        logic    edge_first;
        logic    edge_step;
        logic    pend_clear;
        logic    emit;
        logic    emit_pend;
        logic    emit_last;
        status_t emit_status;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic add_ok;
        logic full;
        logic start_ok;
        logic level_zero;
        logic cur_ok;
        logic pend_valid;
        logic head_ok;
        logic next_ok;
        logic out_free;
    } stat_t;

endpackage

[design/graph_dfs_explicit_stack.sv]
// Top level of the depth-first search block over per-vertex edge lists.
//
// The block takes one item at a time. It accepts the next item in the cycle after the
// final result of the previous one has been loaded into the output register. An add-edge
// item has its result loaded in the add-write state that follows the execute state, and a
// clear or a rejected item in the execute state itself. A search walks the edge store and
// the stack, both memories with one read port and a registered read, with one pop and one
// list head lookup per visited vertex; one edge is followed per cycle. Each visited vertex
// is held back by one result so that the final one can carry the last flag. A stalled
// output side stalls the walk only when a result is ready to leave.
module graph_dfs_explicit_stack #(
    parameter int MAX_VERT  = 32,
    parameter int MAX_EDGES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gdfs_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gdfs_pkg::OP_W-1:0]   op,
    input  logic [gdfs_pkg::VTX_W-1:0]  from_vertex,
    input  logic [gdfs_pkg::VTX_W-1:0]  target_vertex,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gdfs_pkg::VTX_W-1:0]  vertex,
    output logic [gdfs_pkg::ST_W-1:0]   status,
    output logic                        last
);

    gdfs_pkg::cmd_t  cmd;
    gdfs_pkg::stat_t stat;
    logic            cfg_we;

    // The register write always completes in the cycle it is offered.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Controller
    gdfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    gdfs_dp #(
        .MAX_VERT  (MAX_VERT),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .op            (op),
        .from_vertex   (from_vertex),
        .target_vertex (target_vertex),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .vertex        (vertex),
        .status        (status),
        .last          (last),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[design/gdfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/gdfs_ctrl.sv]
// Controller state machine that sequences edge updates and the search walk.
module gdfs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gdfs_pkg::stat_t  stat,
    output gdfs_pkg::cmd_t   cmd
);

    gdfs_pkg::state_t state_reg;
    gdfs_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdfs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdfs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gdfs_pkg::S_EXEC;
                end
            end
            gdfs_pkg::S_EXEC:
            begin
                case (stat.op)
                    gdfs_pkg::OP_ADD:
                    begin
                        if (stat.add_ok && !stat.full)
                        begin
                            state_next = gdfs_pkg::S_ADD_WR;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = gdfs_pkg::S_IDLE;
                        end
                    end
                    gdfs_pkg::OP_SEARCH:
                    begin
                        if (stat.start_ok)
                        begin
                            state_next = gdfs_pkg::S_POP;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = gdfs_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = gdfs_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            gdfs_pkg::S_ADD_WR:
            begin
                if (stat.out_free)
                begin
                    state_next = gdfs_pkg::S_IDLE;
                end
            end
            gdfs_pkg::S_POP:
            begin
                if (stat.level_zero)
                begin
                    state_next = gdfs_pkg::S_FINISH;
                end
                else
                begin
                    state_next = gdfs_pkg::S_VISIT;
                end
            end
            gdfs_pkg::S_VISIT:
            begin
                if (!stat.cur_ok)
                begin
                    state_next = gdfs_pkg::S_POP;
                end
                else if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = gdfs_pkg::S_HEAD;
                end
            end
            gdfs_pkg::S_HEAD:
            begin
                if (stat.head_ok)
                begin
                    state_next = gdfs_pkg::S_EDGE;
                end
                else
                begin
                    state_next = gdfs_pkg::S_POP;
                end
            end
            gdfs_pkg::S_EDGE:
            begin
                if (!stat.next_ok)
                begin
                    state_next = gdfs_pkg::S_POP;
                end
            end
            gdfs_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = gdfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gdfs_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            gdfs_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            gdfs_pkg::S_EXEC:
            begin
                cmd.emit_last = 1'b1;
                case (stat.op)
                    gdfs_pkg::OP_ADD:
                    begin
                        if (!stat.add_ok)
                        begin
                            cmd.emit        = stat.out_free;
                            cmd.emit_status = gdfs_pkg::ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            cmd.emit        = stat.out_free;
                            cmd.emit_status = gdfs_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.head_rd_from = 1'b1;
                        end
                    end
                    gdfs_pkg::OP_SEARCH:
                    begin
                        if (stat.start_ok)
                        begin
                            cmd.push_start = 1'b1;
                        end
                        else
                        begin
                            cmd.emit        = stat.out_free;
                            cmd.emit_status = gdfs_pkg::ST_RANGE;
                        end
                    end
                    gdfs_pkg::OP_CLEAR:
                    begin
                        cmd.clear_all   = stat.out_free;
                        cmd.emit        = stat.out_free;
                        cmd.emit_status = gdfs_pkg::ST_DONE;
                    end
                    default:
                    begin
                        cmd.emit        = stat.out_free;
                        cmd.emit_status = gdfs_pkg::ST_DONE;
                    end
                endcase
            end
            gdfs_pkg::S_ADD_WR:
            begin
                cmd.add_commit  = stat.out_free;
                cmd.emit        = stat.out_free;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = gdfs_pkg::ST_DONE;
            end
            gdfs_pkg::S_POP:
            begin
                cmd.pop = !stat.level_zero;
            end
            gdfs_pkg::S_VISIT:
            begin
                if (stat.cur_ok && (!stat.pend_valid || stat.out_free))
                begin
                    cmd.visit       = 1'b1;
                    cmd.head_rd_cur = 1'b1;
                    cmd.emit        = stat.pend_valid;
                    cmd.emit_pend   = 1'b1;
                    cmd.emit_status = gdfs_pkg::ST_VISIT;
                end
            end
            gdfs_pkg::S_HEAD:
            begin
                cmd.edge_first = stat.head_ok;
            end
            gdfs_pkg::S_EDGE:
            begin
                cmd.edge_step = 1'b1;
            end
            gdfs_pkg::S_FINISH:
            begin
                cmd.emit       = stat.out_free;
                cmd.pend_clear = stat.out_free;
                cmd.emit_last  = 1'b1;
                cmd.emit_pend  = stat.pend_valid;
                if (stat.pend_valid)
                begin
                    cmd.emit_status = gdfs_pkg::ST_VISIT;
                end
                else
                begin
                    cmd.emit_status = gdfs_pkg::ST_NONE;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/gdfs_dp.sv]
// Datapath: edge lists, visited map, walk stack and the result register.
module gdfs_dp #(
    parameter int MAX_VERT  = 32,
    parameter int MAX_EDGES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gdfs_pkg::CNT_W-1:0]        cfg_data,
    input  logic [gdfs_pkg::OP_W-1:0]         op,
    input  logic [gdfs_pkg::VTX_W-1:0]        from_vertex,
    input  logic [gdfs_pkg::VTX_W-1:0]        target_vertex,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [gdfs_pkg::VTX_W-1:0]        vertex,
    output logic [gdfs_pkg::ST_W-1:0]         status,
    output logic                              last,
    input  gdfs_pkg::cmd_t                    cmd,
    output gdfs_pkg::stat_t                   stat
);

    localparam int VIW = $clog2(MAX_VERT);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EPW = $clog2(MAX_EDGES + 1);
    localparam int SD  = MAX_EDGES + 1;
    localparam int SAW = $clog2(SD);
    localparam int SLW = $clog2(SD + 1);
    localparam int VW  = gdfs_pkg::VTX_W;
    localparam int EDW = EPW + VW;

    localparam logic [EPW-1:0] EMPTY    = EPW'(MAX_EDGES);
    localparam logic [6:0]     VLIM     = 7'(MAX_VERT);
    localparam logic [SLW-1:0] STK_FULL = SLW'(SD);

    // Vertex number to map index, widening or narrowing as the map depth needs.
    function automatic logic [VIW-1:0] vidx(input logic [VW-1:0] v);
        logic [VIW+VW-1:0] ext;
        ext = (VIW+VW)'(v);
        return ext[VIW-1:0];
    endfunction

    logic [gdfs_pkg::CNT_W-1:0] vcount_reg;
    logic [gdfs_pkg::OP_W-1:0]  op_reg;
    logic [VW-1:0]              from_reg;
    logic [VW-1:0]              target_reg;
    logic [EPW-1:0]             edges_used_reg;
    logic [MAX_VERT-1:0]        head_vld_reg;
    logic [MAX_VERT-1:0]        visited_reg;
    logic                       head_hit_reg;
    logic [SLW-1:0]             level_reg;
    logic [VW-1:0]              pend_reg;
    logic                       pend_vld_reg;
    logic                       out_valid_reg;
    logic [VW-1:0]              vertex_reg;
    logic [gdfs_pkg::ST_W-1:0]  status_reg;
    logic                       last_reg;

    logic                       head_rd_en;
    logic [VIW-1:0]             head_rd_addr;
    logic [EPW-1:0]             head_rd_data;
    logic                       edge_rd_en;
    logic [EAW-1:0]             edge_rd_addr;
    logic [EDW-1:0]             edge_rd_data;
    logic [EDW-1:0]             edge_wr_data;
    logic [EPW-1:0]             edge_next_f;
    logic [VW-1:0]              edge_dest_f;
    logic                       stk_wr_en;
    logic [SAW-1:0]             stk_wr_addr;
    logic [VW-1:0]              stk_wr_data;
    logic [SLW-1:0]             level_m1;
    logic [VW-1:0]              stk_rd_data;
    logic                       push_ok;
    logic                       from_ok;
    logic                       target_ok;
    logic                       out_free;

    // Vertex range checks against the register and the map depth
    assign from_ok   = (gdfs_pkg::CNT_W'(from_reg) < vcount_reg) && (7'(from_reg) < VLIM);
    assign target_ok = (gdfs_pkg::CNT_W'(target_reg) < vcount_reg)
                       && (7'(target_reg) < VLIM);

    assign edge_next_f = edge_rd_data[EDW-1:VW];
    assign edge_dest_f = edge_rd_data[VW-1:0];
    assign level_m1    = level_reg - SLW'(1);
    assign out_free    = !out_valid_reg || out_ready;

    // A neighbour goes on the stack only if it is in the map and not yet visited.
    assign push_ok = (7'(edge_dest_f) < VLIM) && !visited_reg[vidx(edge_dest_f)]
                     && (level_reg != STK_FULL);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_data;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            from_reg   <= from_vertex;
            target_reg <= target_vertex;
        end
    end

    // Edge store fill level and list head valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_used_reg <= '0;
            head_vld_reg   <= '0;
        end
        else if (cmd.clear_all)
        begin
            edges_used_reg <= '0;
            head_vld_reg   <= '0;
        end
        else if (cmd.add_commit)
        begin
            edges_used_reg              <= edges_used_reg + EPW'(1);
            head_vld_reg[vidx(from_reg)] <= 1'b1;
        end
    end

    // List head read, with the valid bit of the entry read
    assign head_rd_en   = cmd.head_rd_from || cmd.head_rd_cur;
    assign head_rd_addr = cmd.head_rd_cur ? vidx(stk_rd_data) : vidx(from_reg);

    always_ff @(posedge clk)
    begin
        if (head_rd_en)
        begin
            head_hit_reg <= head_vld_reg[head_rd_addr];
        end
    end

    gdfs_ram #(
        .WIDTH (EPW),
        .DEPTH (MAX_VERT)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (cmd.add_commit),
        .wr_addr (vidx(from_reg)),
        .wr_data (edges_used_reg),
        .rd_en   (head_rd_en),
        .rd_addr (head_rd_addr),
        .rd_data (head_rd_data)
    );

    // Edge store: next pointer and destination of each edge
    assign edge_wr_data = {(head_hit_reg ? head_rd_data : EMPTY), target_reg};
    assign edge_rd_en   = cmd.edge_first || (cmd.edge_step && stat.next_ok);
    assign edge_rd_addr = cmd.edge_first ? head_rd_data[EAW-1:0] : edge_next_f[EAW-1:0];

    gdfs_ram #(
        .WIDTH (EDW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (cmd.add_commit),
        .wr_addr (edges_used_reg[EAW-1:0]),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    // Walk stack: the start vertex at the bottom, neighbours pushed on top
    assign stk_wr_en   = cmd.push_start || (cmd.edge_step && push_ok);
    assign stk_wr_addr = cmd.push_start ? '0 : level_reg[SAW-1:0];
    assign stk_wr_data = cmd.push_start ? target_reg : edge_dest_f;

    gdfs_ram #(
        .WIDTH (VW),
        .DEPTH (SD)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (cmd.pop),
        .rd_addr (level_m1[SAW-1:0]),
        .rd_data (stk_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cmd.push_start)
        begin
            level_reg <= SLW'(1);
        end
        else if (cmd.pop)
        begin
            level_reg <= level_m1;
        end
        else if (cmd.edge_step && push_ok)
        begin
            level_reg <= level_reg + SLW'(1);
        end
    end

    // Visited map and the held-back vertex that waits for its last flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.visit)
            begin
                visited_reg[vidx(stk_rd_data)] <= 1'b1;
            end
            if (cmd.push_start || cmd.pend_clear)
            begin
                pend_vld_reg <= 1'b0;
            end
            else if (cmd.visit)
            begin
                pend_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.visit)
        begin
            pend_reg <= stk_rd_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            vertex_reg <= cmd.emit_pend ? pend_reg : '0;
            status_reg <= cmd.emit_status;
            last_reg   <= cmd.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex    = vertex_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Status towards the controller
    always_comb
    begin
        stat            = '0;
        stat.op         = gdfs_pkg::op_t'(op_reg);
        stat.add_ok     = from_ok && target_ok;
        stat.full       = (edges_used_reg == EMPTY);
        stat.start_ok   = target_ok;
        stat.level_zero = (level_reg == '0);
        stat.cur_ok     = (7'(stk_rd_data) < VLIM) && !visited_reg[vidx(stk_rd_data)];
        stat.pend_valid = pend_vld_reg;
        stat.head_ok    = head_hit_reg;
        stat.next_ok    = (edge_next_f != EMPTY);
        stat.out_free   = out_free;
    end

endmodule
